/* hdl/mfmt_pkg.sv */
`timescale 1ns / 1ps

package mfmt_pkg;

   localparam int unsigned TURN_WIDTH = 19;

   localparam logic [3:0] FULL_FRAME_LENGTH = 4'd8;

   localparam logic [TURN_WIDTH-1:0] TURN_MAX = {1'b0, {(TURN_WIDTH-1){1'b1}}};
   localparam logic [TURN_WIDTH-1:0] TURN_MIN = {1'b1, {(TURN_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic [2:0]  motor_index;
      logic [63:0] frame_bytes;
      logic [3:0]  frame_length;
   } req_type;

   typedef struct packed {
      logic [2:0]         out_motor;
      logic [15:0]        angle;
      logic signed [15:0] speed_rpm;
      logic signed [15:0] motor_current;
      logic [7:0]         temperature;
      logic signed [31:0] total_angle;
      logic               first_sample;
   } rsp_type;

   typedef struct packed {
      logic [2:0]         motor_index;
      logic [15:0]        angle;
      logic signed [15:0] speed_rpm;
      logic signed [15:0] motor_current;
      logic [7:0]         temperature;
   } item_type;

endpackage

/* hdl/mfmt_front.sv */
`timescale 1ns / 1ps

module mfmt_front #(
   parameter int MOTOR_COUNT     = 8,
   parameter int COUNTS_PER_TURN = 8192
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mfmt_pkg::req_type req_payload,
   input  logic              csr_write_enable,
   input  logic [7:0]        csr_write_data,
   output logic              item_valid,
   output mfmt_pkg::item_type item,
   input  logic              item_take
);

   localparam logic [31:0] MOTOR_LIMIT = 32'(MOTOR_COUNT);
   localparam logic [15:0] CPT_ANGLE   = 16'(COUNTS_PER_TURN);

   logic               valid_ff;
   logic               valid_in;
   mfmt_pkg::item_type item_ff;
   mfmt_pkg::item_type item_in;
   logic [7:0]         invert_ff;
   logic [7:0]         invert_in;
   logic               load;
   logic               keep;
   logic               invert_bit;
   logic [15:0]        raw_angle;
   logic [15:0]        raw_speed;
   logic [15:0]        raw_current;

   assign load      = !valid_ff || item_take;
   assign req_stall = !load;

   always_comb begin
      raw_angle   = req_payload.frame_bytes[63:48];
      raw_speed   = req_payload.frame_bytes[47:32];
      raw_current = req_payload.frame_bytes[31:16];
      invert_bit  = invert_ff[req_payload.motor_index];
      keep        = (req_payload.frame_length >= mfmt_pkg::FULL_FRAME_LENGTH)
                    && (32'(req_payload.motor_index) < MOTOR_LIMIT);

      item_in.motor_index = req_payload.motor_index;
      item_in.temperature = req_payload.frame_bytes[15:8];
      if (invert_bit) begin
         item_in.angle         = (raw_angle != 16'd0) ? 16'(CPT_ANGLE - raw_angle) : 16'd0;
         item_in.speed_rpm     = $signed(16'(16'd0 - raw_speed));
         item_in.motor_current = $signed(16'(16'd0 - raw_current));
      end else begin
         item_in.angle         = raw_angle;
         item_in.speed_rpm     = $signed(raw_speed);
         item_in.motor_current = $signed(raw_current);
      end
   end

   always_comb begin
      valid_in  = valid_ff;
      invert_in = invert_ff;
      if (load) begin
         valid_in = req_valid && keep;
      end
      if (csr_write_enable) begin
         invert_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         invert_ff <= 8'd0;
      end else begin
         valid_ff  <= valid_in;
         invert_ff <= invert_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* hdl/mfmt_track.sv */
`timescale 1ns / 1ps

module mfmt_track #(
   parameter int MOTOR_COUNT     = 8,
   parameter int COUNTS_PER_TURN = 8192
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  mfmt_pkg::item_type item,
   output logic               item_take,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mfmt_pkg::rsp_type  rsp_payload
);

   localparam int unsigned INDEX_WIDTH = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
   localparam int unsigned TW          = mfmt_pkg::TURN_WIDTH;
   localparam logic [31:0] CPT_WORD    = 32'(COUNTS_PER_TURN);
   localparam logic [TW-1:0] TURN_STEP = {{(TW-1){1'b0}}, 1'b1};
   localparam logic signed [17:0] HALF_POS = 18'(COUNTS_PER_TURN / 2);
   localparam logic signed [17:0] HALF_NEG = 18'(-(COUNTS_PER_TURN / 2));
   localparam logic [31:0] BASE_MIN =
      32'(-(longint'(1) << (TW - 1)) * longint'(COUNTS_PER_TURN));
   localparam logic [31:0] BASE_MAX =
      32'(((longint'(1) << (TW - 1)) - 1) * longint'(COUNTS_PER_TURN));

   logic [15:0]            prev_ff [MOTOR_COUNT];
   logic [TW-1:0]          turn_ff [MOTOR_COUNT];
   logic [31:0]            base_ff [MOTOR_COUNT];
   logic [MOTOR_COUNT-1:0] seen_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   mfmt_pkg::rsp_type      rsp_ff;
   mfmt_pkg::rsp_type      rsp_in;

   logic [31:0]            index_wide;
   logic [INDEX_WIDTH-1:0] idx;
   logic                   fire;
   logic                   seen;
   logic [15:0]            prev;
   logic [TW-1:0]          turn;
   logic [31:0]            base;
   logic [17:0]            delta;
   logic [TW-1:0]          turn_in;
   logic [31:0]            base_in;

   assign item_take = !rsp_valid_ff || !rsp_stall;
   assign fire      = item_valid && item_take;

   always_comb begin
      index_wide = 32'(item.motor_index);
      idx        = index_wide[INDEX_WIDTH-1:0];
      seen       = seen_ff[idx];
      prev       = prev_ff[idx];
      turn       = turn_ff[idx];
      base       = base_ff[idx];
      delta      = {2'b00, item.angle} - {2'b00, prev};

      turn_in = turn;
      base_in = base;
      if (seen) begin
         priority if ($signed(delta) > HALF_POS) begin
            if (turn == mfmt_pkg::TURN_MIN) begin
               turn_in = mfmt_pkg::TURN_MAX;
               base_in = BASE_MAX;
            end else begin
               turn_in = turn - TURN_STEP;
               base_in = base - CPT_WORD;
            end
         end else if ($signed(delta) < HALF_NEG) begin
            if (turn == mfmt_pkg::TURN_MAX) begin
               turn_in = mfmt_pkg::TURN_MIN;
               base_in = BASE_MIN;
            end else begin
               turn_in = turn + TURN_STEP;
               base_in = base + CPT_WORD;
            end
         end
      end

      rsp_in.out_motor     = item.motor_index;
      rsp_in.angle         = item.angle;
      rsp_in.speed_rpm     = item.speed_rpm;
      rsp_in.motor_current = item.motor_current;
      rsp_in.temperature   = item.temperature;
      rsp_in.first_sample  = !seen;
      if (seen) begin
         rsp_in.total_angle = $signed(base_in + {16'd0, item.angle});
      end else begin
         rsp_in.total_angle = $signed({16'd0, item.angle});
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         seen_ff      <= '0;
         for (int m = 0; m < MOTOR_COUNT; m++) begin
            turn_ff[m] <= '0;
            base_ff[m] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            seen_ff[idx] <= 1'b1;
            turn_ff[idx] <= turn_in;
            base_ff[idx] <= base_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         prev_ff[idx] <= item.angle;
         rsp_ff       <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // hold the stage only behind a full, stalled result register
   a_hold_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      item_valid && !item_take |-> rsp_valid_ff && rsp_stall)
      else $error("item held without a blocked result");

   a_first_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.first_sample |-> rsp_ff.total_angle == $signed({16'd0, rsp_ff.angle}))
      else $error("first sample total differs from angle");

   a_seen_after_fire: assert property (@(posedge clock) disable iff (reset)
      fire |=> seen_ff[$past(idx)])
      else $error("motor not marked seen");

   a_base_matches_turn: assert property (@(posedge clock) disable iff (reset)
      $past(fire) && !$past(reset) |->
         base_ff[$past(idx)] ==
            32'($signed(turn_ff[$past(idx)]) * longint'(COUNTS_PER_TURN)))
      else $error("turn base out of step with turn count");

   a_result_after_fire: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff && rsp_ff.out_motor == $past(item.motor_index))
      else $error("result missing after item");

endmodule

/* hdl/motor_feedback_multiturn_tracker_top.sv */
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// req_      in         req_valid / req_stall      mfmt_pkg::req_type
// rsp_      out        rsp_valid / rsp_stall      mfmt_pkg::rsp_type
// csr_      in         csr_write_enable           invert mask, 8 bits
//
// One item per cycle while the result is not stalled; each item passes the input register
// and then the result register, and a result leaves once rsp_stall is low.
// The input register and the result register sit around the per-motor
// read-modify-write of angle, turn count and turn base.
// Reset clears the valid flags, the invert mask, the seen flags and the turn state.
// A stalled result holds the tracking stage; the input stalls only then.
// Short frames and out-of-range motors are dropped at the input and give no result.

module motor_feedback_multiturn_tracker_top #(
   parameter int MOTOR_COUNT     = 8,
   parameter int COUNTS_PER_TURN = 8192
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mfmt_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mfmt_pkg::rsp_type rsp_payload,
   input  logic              csr_write_enable,
   input  logic [7:0]        csr_write_data
);

   logic               item_valid;
   logic               item_take;
   mfmt_pkg::item_type item;

   mfmt_front #(
      .MOTOR_COUNT     (MOTOR_COUNT),
      .COUNTS_PER_TURN (COUNTS_PER_TURN)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_valid       (item_valid),
      .item             (item),
      .item_take        (item_take)
   );

   mfmt_track #(
      .MOTOR_COUNT     (MOTOR_COUNT),
      .COUNTS_PER_TURN (COUNTS_PER_TURN)
   ) u_track (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item        (item),
      .item_take   (item_take),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
